[rtl/nnsb_pkg.sv]
// ----------------------------------------------------------------------------
// nnsb_pkg
// Shared types and constants for the nearest neighbor scaled blit.
// ----------------------------------------------------------------------------
`default_nettype none

package nnsb_pkg;

  // Fixed-point format of the source walk
  localparam int FRAC_BITS  = 16;
  localparam int SRC_DIM_W  = 7;
  localparam int DEST_DIM_W = 11;
  localparam int POS_W      = 12;
  localparam int STEP_W     = SRC_DIM_W + FRAC_BITS;
  localparam int ACC_W      = 24;
  localparam int SRC_INT_W  = ACC_W - FRAC_BITS;
  localparam int SIDX_W     = SRC_INT_W + SRC_DIM_W + 1;
  localparam int DIV_CNT_W  = $clog2(STEP_W + 1);

  // Port widths
  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 12;
  localparam int COLOR_W     = 16;
  localparam int PIX_W       = 11;
  localparam int PIX_INDEX_W = 22;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Input modes
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

  // Classified operations
  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD    = 2'd0;
  localparam op_t OP_START   = 2'd1;
  localparam op_t OP_ADVANCE = 2'd2;
  localparam op_t OP_NONE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_COLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS  = 3'd5;

  typedef struct packed {
    logic [POS_W-1:0]      dest_left;
    logic [POS_W-1:0]      dest_top;
    logic [DEST_DIM_W-1:0] dest_cols;
    logic [DEST_DIM_W-1:0] dest_rows;
    logic [SRC_DIM_W-1:0]  src_cols;
    logic [SRC_DIM_W-1:0]  src_rows;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
  } req_t;

endpackage

`default_nettype wire

[rtl/nnsb_front.sv]
// ----------------------------------------------------------------------------
// nnsb_front
// Accepts input requests and classifies them into operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsb_front #(
  parameter int STORE_DEPTH = 4096
) (
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [nnsb_pkg::MODE_W-1:0]  in_mode,
  input  wire  [nnsb_pkg::INDEX_W-1:0] in_load_index,
  input  wire  [nnsb_pkg::COLOR_W-1:0] in_load_color,
  input  wire                          q_full,
  output logic                         push,
  output nnsb_pkg::req_t               push_req
);
  import nnsb_pkg::*;

  logic load_ok;

  // Take a request whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign load_ok  = 32'(in_load_index) < 32'(STORE_DEPTH);

  // Classify the mode; loads beyond the store and unknown modes become no-ops
  always_comb begin
    push_req.index = in_load_index;
    push_req.color = in_load_color;
    unique case (in_mode)
      MODE_LOAD:    push_req.op = load_ok ? OP_LOAD : OP_NONE;
      MODE_START:   push_req.op = OP_START;
      MODE_ADVANCE: push_req.op = OP_ADVANCE;
      default:      push_req.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/nnsb_queue.sv]
// ----------------------------------------------------------------------------
// nnsb_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsb_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  nnsb_pkg::req_t  push_req,
  output logic            full,
  input  wire             pop,
  output logic            head_valid,
  output nnsb_pkg::req_t  head_req
);
  import nnsb_pkg::*;

  req_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full       = count_r == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_req   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/nnsb_div.sv]
// ----------------------------------------------------------------------------
// nnsb_div
// Serial restoring divider, one quotient bit per cycle, for the walk steps.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsb_div (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire  [nnsb_pkg::STEP_W-1:0]     dividend,
  input  wire  [nnsb_pkg::DEST_DIM_W-1:0] divisor,
  output logic                            busy,
  output logic [nnsb_pkg::STEP_W-1:0]     quotient
);
  import nnsb_pkg::*;

  logic [DEST_DIM_W-1:0] rem_r;
  logic [DEST_DIM_W-1:0] rem_nxt;
  logic [DEST_DIM_W-1:0] divisor_r;
  logic [STEP_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic [DEST_DIM_W:0]   trial;
  logic                  fits;

  assign busy     = busy_r;
  assign quotient = quo_r;

  // Shift in the next dividend bit and try a subtract
  assign trial   = {rem_r, quo_r[STEP_W-1]};
  assign fits    = trial >= {1'b0, divisor_r};
  assign rem_nxt = fits ? DEST_DIM_W'(trial - {1'b0, divisor_r}) : trial[DEST_DIM_W-1:0];

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[STEP_W-2:0], fits};
    end
  end

  // Count the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(STEP_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/nnsb_back.sv]
// ----------------------------------------------------------------------------
// nnsb_back
// Executes queued requests: source store writes, blit start with step
// division, and the destination walk with clipping and framebuffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsb_back #(
  parameter int SCREEN_WIDTH   = 800,
  parameter int SCREEN_HEIGHT  = 480,
  parameter int SRC_MAX_WIDTH  = 64,
  parameter int SRC_MAX_HEIGHT = 64,
  parameter int STORE_DEPTH    = 4096,
  parameter int STORE_AW       = 12
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  nnsb_pkg::cfg_t                   cfg,
  input  wire                              head_valid,
  input  nnsb_pkg::req_t                   head_req,
  output logic                             pop,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_write_valid,
  output logic [nnsb_pkg::PIX_W-1:0]       out_pixel_x,
  output logic [nnsb_pkg::PIX_W-1:0]       out_pixel_y,
  output logic [nnsb_pkg::PIX_INDEX_W-1:0] out_pixel_index,
  output logic [nnsb_pkg::COLOR_W-1:0]     out_color,
  output logic                             out_done_res
);
  import nnsb_pkg::*;

  // Source store
  logic [COLOR_W-1:0] store_mem [STORE_DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  // Walk state
  logic                  finished_r, finished_nxt;
  logic [ACC_W-1:0]      x_acc_r, x_acc_nxt;
  logic [ACC_W-1:0]      y_acc_r, y_acc_nxt;
  logic [DEST_DIM_W-1:0] col_r, col_nxt;
  logic [DEST_DIM_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0]      lat_left_r;
  logic [POS_W-1:0]      lat_top_r;
  logic [DEST_DIM_W-1:0] lat_cols_r;
  logic [DEST_DIM_W-1:0] lat_rows_r;
  logic [SRC_DIM_W-1:0]  lat_stride_r;

  // Step dividers
  logic              div_start;
  logic              div_busy_x;
  logic              div_busy_y;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;

  // Pipeline stages
  logic                s1_valid_r;
  logic                s1_wr_r;
  logic                s1_keep_r;
  logic                s1_done_r;
  logic [PIX_W-1:0]    s1_px_r;
  logic [PIX_W-1:0]    s1_py_r;
  logic [STORE_AW-1:0] s1_addr_r;
  logic                s2_valid_r;
  logic                s2_wr_r;
  logic                s2_keep_r;
  logic                s2_done_r;
  logic [PIX_W-1:0]    s2_px_r;
  logic [PIX_W-1:0]    s2_py_r;
  logic [PIX_INDEX_W-1:0] s2_pix_idx_r;

  // Issue logic
  logic                 en;
  logic                 issue;
  logic [SRC_DIM_W-1:0] sw;
  logic [SRC_DIM_W-1:0] sh;
  logic                 empty_blit;
  logic [POS_W:0]       px_s;
  logic [POS_W:0]       py_s;
  logic                 on_screen;
  logic [SIDX_W-1:0]    sidx;
  logic                 in_range;
  logic                 last_col;
  logic                 last_row;
  logic                 res_wr;
  logic                 res_keep;
  logic                 res_done;

  // Stall everything behind a result that has not been taken
  assign en    = !s2_valid_r || out_ready;
  assign issue = en && head_valid && !div_busy_x && !div_busy_y;
  assign pop   = issue;

  // Saturate the source size and detect an empty blit
  assign sw = (32'(cfg.src_cols) > 32'(SRC_MAX_WIDTH))  ? SRC_DIM_W'(SRC_MAX_WIDTH)  : cfg.src_cols;
  assign sh = (32'(cfg.src_rows) > 32'(SRC_MAX_HEIGHT)) ? SRC_DIM_W'(SRC_MAX_HEIGHT) : cfg.src_rows;
  assign empty_blit = (cfg.dest_cols == '0) || (cfg.dest_rows == '0) ||
                      (sw == '0) || (sh == '0);

  // Screen position and clipping
  assign px_s = {lat_left_r[POS_W-1], lat_left_r} + {2'b00, col_r};
  assign py_s = {lat_top_r[POS_W-1], lat_top_r} + {2'b00, row_r};
  assign on_screen = !px_s[POS_W] && (px_s[POS_W-1:0] < POS_W'(SCREEN_WIDTH)) &&
                     !py_s[POS_W] && (py_s[POS_W-1:0] < POS_W'(SCREEN_HEIGHT));

  // Nearest source pixel address
  assign sidx = SIDX_W'({{SRC_DIM_W{1'b0}}, y_acc_r[ACC_W-1:FRAC_BITS]} *
                        {{SRC_INT_W{1'b0}}, lat_stride_r}) +
                SIDX_W'(x_acc_r[ACC_W-1:FRAC_BITS]);
  assign in_range = 32'(sidx) < 32'(STORE_DEPTH);

  assign last_col = ({1'b0, col_r} + 1'b1) >= {1'b0, lat_cols_r};
  assign last_row = ({1'b0, row_r} + 1'b1) >= {1'b0, lat_rows_r};

  assign div_start = issue && (head_req.op == OP_START) && !empty_blit;

  // Decide the result and next walk state of the head request
  always_comb begin
    finished_nxt = finished_r;
    x_acc_nxt    = x_acc_r;
    y_acc_nxt    = y_acc_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    res_wr       = 1'b0;
    res_keep     = 1'b0;
    res_done     = 1'b0;
    unique case (head_req.op)
      OP_START: begin
        x_acc_nxt    = '0;
        y_acc_nxt    = '0;
        col_nxt      = '0;
        row_nxt      = '0;
        finished_nxt = empty_blit;
        res_done     = empty_blit;
      end
      OP_ADVANCE: begin
        if (finished_r) begin
          res_done = 1'b1;
        end else begin
          res_wr   = on_screen;
          res_keep = on_screen && in_range;
          if (last_col) begin
            col_nxt   = '0;
            x_acc_nxt = '0;
            if (last_row) begin
              finished_nxt = 1'b1;
              res_done     = 1'b1;
            end else begin
              row_nxt   = row_r + 1'b1;
              y_acc_nxt = y_acc_r + ACC_W'(step_y);
            end
          end else begin
            col_nxt   = col_r + 1'b1;
            x_acc_nxt = x_acc_r + ACC_W'(step_x);
          end
        end
      end
      OP_LOAD, OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Update walk state and latch geometry at start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r   <= 1'b1;
      x_acc_r      <= '0;
      y_acc_r      <= '0;
      col_r        <= '0;
      row_r        <= '0;
      lat_left_r   <= '0;
      lat_top_r    <= '0;
      lat_cols_r   <= '0;
      lat_rows_r   <= '0;
      lat_stride_r <= '0;
    end else if (issue) begin
      finished_r <= finished_nxt;
      x_acc_r    <= x_acc_nxt;
      y_acc_r    <= y_acc_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      if (div_start) begin
        lat_left_r   <= cfg.dest_left;
        lat_top_r    <= cfg.dest_top;
        lat_cols_r   <= cfg.dest_cols;
        lat_rows_r   <= cfg.dest_rows;
        lat_stride_r <= sw;
      end
    end
  end

  nnsb_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sw, {FRAC_BITS{1'b0}}}),
    .divisor  (cfg.dest_cols),
    .busy     (div_busy_x),
    .quotient (step_x)
  );

  nnsb_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sh, {FRAC_BITS{1'b0}}}),
    .divisor  (cfg.dest_rows),
    .busy     (div_busy_y),
    .quotient (step_y)
  );

  // Write loads into the store; read the pixel of the request in stage one
  always_ff @(posedge clk) begin
    if (issue && (head_req.op == OP_LOAD)) begin
      store_mem[STORE_AW'(head_req.index)] <= head_req.color;
    end
    if (en) begin
      rd_data_r <= store_mem[s1_addr_r];
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_wr_r   <= res_wr;
      s1_keep_r <= res_keep;
      s1_done_r <= res_done;
      s1_px_r   <= res_wr ? px_s[PIX_W-1:0] : '0;
      s1_py_r   <= res_wr ? py_s[PIX_W-1:0] : '0;
      s1_addr_r <= STORE_AW'(sidx);

      s2_wr_r      <= s1_wr_r;
      s2_keep_r    <= s1_keep_r;
      s2_done_r    <= s1_done_r;
      s2_px_r      <= s1_px_r;
      s2_py_r      <= s1_py_r;
      s2_pix_idx_r <= PIX_INDEX_W'({{(PIX_INDEX_W-PIX_W){1'b0}}, s1_py_r} *
                                   PIX_INDEX_W'(SCREEN_WIDTH)) +
                      {{(PIX_INDEX_W-PIX_W){1'b0}}, s1_px_r};
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_write_valid = s2_wr_r;
  assign out_pixel_x     = s2_px_r;
  assign out_pixel_y     = s2_py_r;
  assign out_pixel_index = s2_pix_idx_r;
  assign out_color       = s2_keep_r ? rd_data_r : '0;
  assign out_done_res    = s2_done_r;

endmodule

`default_nettype wire

[rtl/nearest_neighbor_scaled_blit.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_blit
// Nearest neighbor scaling of an RGB565 source image onto a screen.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Loads, advances and no-op requests
// flow at one per cycle while results are taken and no division runs. A start
// with nonzero geometry runs two serial dividers in parallel, one quotient bit
// per cycle, so requests behind it wait until both dividers are done
// before they issue; the front keeps accepting into a four-entry queue during
// that time. The source store is a single-port-write, single-read memory of
// SRC_MAX_WIDTH x SRC_MAX_HEIGHT words, and entries must be loaded before an
// advance reads them. Geometry is sampled when a start request issues.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_scaled_blit #(
  parameter int SCREEN_WIDTH   = 800,
  parameter int SCREEN_HEIGHT  = 480,
  parameter int SRC_MAX_WIDTH  = 64,
  parameter int SRC_MAX_HEIGHT = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [nnsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [nnsb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [nnsb_pkg::MODE_W-1:0]      in_mode,
  input  wire  [nnsb_pkg::INDEX_W-1:0]     in_load_index,
  input  wire  [nnsb_pkg::COLOR_W-1:0]     in_load_color,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_write_valid,
  output logic [nnsb_pkg::PIX_W-1:0]       out_pixel_x,
  output logic [nnsb_pkg::PIX_W-1:0]       out_pixel_y,
  output logic [nnsb_pkg::PIX_INDEX_W-1:0] out_pixel_index,
  output logic [nnsb_pkg::COLOR_W-1:0]     out_color,
  output logic                             out_done_res
);
  import nnsb_pkg::*;

  localparam int STORE_DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  cfg_t cfg_r;
  logic q_full;
  logic push;
  req_t push_req;
  logic pop;
  logic head_valid;
  req_t head_req;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_LEFT: cfg_r.dest_left <= cfg_wdata[POS_W-1:0];
        REG_DEST_TOP:  cfg_r.dest_top  <= cfg_wdata[POS_W-1:0];
        REG_DEST_COLS: cfg_r.dest_cols <= cfg_wdata[DEST_DIM_W-1:0];
        REG_DEST_ROWS: cfg_r.dest_rows <= cfg_wdata[DEST_DIM_W-1:0];
        REG_SRC_COLS:  cfg_r.src_cols  <= cfg_wdata[SRC_DIM_W-1:0];
        REG_SRC_ROWS:  cfg_r.src_rows  <= cfg_wdata[SRC_DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nnsb_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_load_index (in_load_index),
    .in_load_color (in_load_color),
    .q_full        (q_full),
    .push          (push),
    .push_req      (push_req)
  );

  nnsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  nnsb_back #(
    .SCREEN_WIDTH   (SCREEN_WIDTH),
    .SCREEN_HEIGHT  (SCREEN_HEIGHT),
    .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
    .STORE_DEPTH    (STORE_DEPTH),
    .STORE_AW       (STORE_AW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (head_valid),
    .head_req        (head_req),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_valid (out_write_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_index (out_pixel_index),
    .out_color       (out_color),
    .out_done_res    (out_done_res)
  );

endmodule

`default_nettype wire
